// ----- src/sha_pkg.sv -----
// Shared types and constants of the SHA-256 hasher core.
package sha_pkg;

   localparam logic [7:0] PadByte = 8'h80;

   typedef logic [31:0] word_type;

   typedef struct packed {
      logic load_byte;    // write the input byte at the current position
      logic load_pad;     // write a pad byte at pad_pos
      logic [5:0] pad_pos;
      logic [7:0] pad_val;
      logic start_block;  // latch the chain state and begin the rounds
      logic round_step;   // do one round
      logic finish_block; // add the working state into the chain state
      logic reset_chain;  // restore the initial hash, zero the count
      logic shift_digest; // move to the next digest word
   } cmd_type;

   typedef struct packed {
      logic [5:0] fill_pos;   // low six bits of the byte count
      logic [5:0] round_num;
      logic [63:0] bit_len;
   } status_type;

   function automatic word_type init_hash(input logic [2:0] idx);
      word_type v;
      case (idx)
         3'd0: v = 32'h6a09e667;
         3'd1: v = 32'hbb67ae85;
         3'd2: v = 32'h3c6ef372;
         3'd3: v = 32'ha54ff53a;
         3'd4: v = 32'h510e527f;
         3'd5: v = 32'h9b05688c;
         3'd6: v = 32'h1f83d9ab;
         default: v = 32'h5be0cd19;
      endcase
      return v;
   endfunction

   function automatic word_type round_k(input logic [5:0] idx);
      word_type v;
      case (idx)
         6'd0: v = 32'h428a2f98; 6'd1: v = 32'h71374491; 6'd2: v = 32'hb5c0fbcf;
         6'd3: v = 32'he9b5dba5; 6'd4: v = 32'h3956c25b; 6'd5: v = 32'h59f111f1;
         6'd6: v = 32'h923f82a4; 6'd7: v = 32'hab1c5ed5; 6'd8: v = 32'hd807aa98;
         6'd9: v = 32'h12835b01; 6'd10: v = 32'h243185be; 6'd11: v = 32'h550c7dc3;
         6'd12: v = 32'h72be5d74; 6'd13: v = 32'h80deb1fe; 6'd14: v = 32'h9bdc06a7;
         6'd15: v = 32'hc19bf174; 6'd16: v = 32'he49b69c1; 6'd17: v = 32'hefbe4786;
         6'd18: v = 32'h0fc19dc6; 6'd19: v = 32'h240ca1cc; 6'd20: v = 32'h2de92c6f;
         6'd21: v = 32'h4a7484aa; 6'd22: v = 32'h5cb0a9dc; 6'd23: v = 32'h76f988da;
         6'd24: v = 32'h983e5152; 6'd25: v = 32'ha831c66d; 6'd26: v = 32'hb00327c8;
         6'd27: v = 32'hbf597fc7; 6'd28: v = 32'hc6e00bf3; 6'd29: v = 32'hd5a79147;
         6'd30: v = 32'h06ca6351; 6'd31: v = 32'h14292967; 6'd32: v = 32'h27b70a85;
         6'd33: v = 32'h2e1b2138; 6'd34: v = 32'h4d2c6dfc; 6'd35: v = 32'h53380d13;
         6'd36: v = 32'h650a7354; 6'd37: v = 32'h766a0abb; 6'd38: v = 32'h81c2c92e;
         6'd39: v = 32'h92722c85; 6'd40: v = 32'ha2bfe8a1; 6'd41: v = 32'ha81a664b;
         6'd42: v = 32'hc24b8b70; 6'd43: v = 32'hc76c51a3; 6'd44: v = 32'hd192e819;
         6'd45: v = 32'hd6990624; 6'd46: v = 32'hf40e3585; 6'd47: v = 32'h106aa070;
         6'd48: v = 32'h19a4c116; 6'd49: v = 32'h1e376c08; 6'd50: v = 32'h2748774c;
         6'd51: v = 32'h34b0bcb5; 6'd52: v = 32'h391c0cb3; 6'd53: v = 32'h4ed8aa4a;
         6'd54: v = 32'h5b9cca4f; 6'd55: v = 32'h682e6ff3; 6'd56: v = 32'h748f82ee;
         6'd57: v = 32'h78a5636f; 6'd58: v = 32'h84c87814; 6'd59: v = 32'h8cc70208;
         6'd60: v = 32'h90befffa; 6'd61: v = 32'ha4506ceb; 6'd62: v = 32'hbef9a3f7;
         default: v = 32'hc67178f2;
      endcase
      return v;
   endfunction

endpackage

// ----- src/sha256_hasher_core.sv -----
// SHA-256 hasher core: one byte per transfer, digest returned as eight 32-bit words.
// A byte that does not fill a block leaves the core ready for the next byte; a full
// block adds a load step, 64 rounds on the single round unit and one chain update.
// End of message adds one pad byte write per cycle and one or two compressions,
// then eight result transfers and a step that restores the initial hash.
// Synchronous active-high reset sets the initial hash and a zero byte count.
module sha256_hasher_core (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,  // [7:0] data_byte
   input  logic [0:0] req_tuser,  // [0] byte_present
   input  logic req_tlast,        // end_of_message
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [39:0] rsp_tdata, // [31:0] digest_word, [34:32] word_index, rest zero
   output logic rsp_tlast         // last_word
);
   import sha_pkg::*;

   cmd_type cmd;
   status_type status;
   logic [31:0] digest_word;
   logic [2:0] word_index;

   sha_control u_control (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .byte_present(req_tuser[0]), .end_of_message(req_tlast),
      .status(status), .cmd(cmd),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .word_index(word_index)
   );

   sha_datapath u_datapath (
      .clock(clock), .reset(reset),
      .data_byte(req_tdata), .cmd(cmd), .status(status), .digest_word(digest_word)
   );

   assign rsp_tdata = {5'd0, word_index, digest_word};
   assign rsp_tlast = (word_index == 3'd7);

endmodule

// ----- src/sha_datapath.sv -----
// Datapath of the SHA-256 hasher: message schedule that gathers the block, rounds and chain state.
module sha_datapath (
   input  logic clock,
   input  logic reset,
   input  logic [7:0] data_byte,
   input  sha_pkg::cmd_type cmd,
   output sha_pkg::status_type status,
   output logic [31:0] digest_word
);
   import sha_pkg::*;

   logic [63:0] count_ff, count_in;
   word_type chain_ff [8];
   word_type work_ff [8];
   word_type sched_ff [16];
   logic [5:0] round_ff;
   logic wr_en;
   logic [5:0] wr_pos;
   logic [7:0] wr_byte;

   // Byte count, wraps modulo 2^64.
   always_comb begin
      count_in = count_ff;
      if (cmd.reset_chain) count_in = '0;
      else if (cmd.load_byte) count_in = count_ff + 64'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else count_ff <= count_in;
   end

   assign wr_en = cmd.load_byte || cmd.load_pad;
   assign wr_pos = cmd.load_byte ? count_ff[5:0] : cmd.pad_pos;
   assign wr_byte = cmd.load_byte ? data_byte : cmd.pad_val;

   word_type a, e, s0w, s1w, w_new, t1, t2, big0, big1, ch, maj;

   always_comb begin
      a = work_ff[0];
      e = work_ff[4];
      big1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
      ch = (e & work_ff[5]) ^ (~e & work_ff[6]);
      t1 = work_ff[7] + big1 + ch + round_k(round_ff) + sched_ff[0];
      big0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
      maj = (a & work_ff[1]) ^ (a & work_ff[2]) ^ (work_ff[1] & work_ff[2]);
      t2 = big0 + maj;
      s0w = {sched_ff[1][6:0], sched_ff[1][31:7]} ^ {sched_ff[1][17:0], sched_ff[1][31:18]}
            ^ (sched_ff[1] >> 3);
      s1w = {sched_ff[14][16:0], sched_ff[14][31:17]}
            ^ {sched_ff[14][18:0], sched_ff[14][31:19]} ^ (sched_ff[14] >> 10);
      w_new = s1w + sched_ff[9] + s0w + sched_ff[0];
   end

   // The schedule window doubles as the block buffer: bytes land big-endian in
   // their word while no block is in the rounds, and every byte of a block is
   // written by a message byte or a pad byte before the rounds start.
   always_ff @(posedge clock) begin
      if (cmd.round_step) begin
         for (int i = 0; i < 15; i++) sched_ff[i] <= sched_ff[i+1];
         sched_ff[15] <= w_new;
      end else if (wr_en) begin
         sched_ff[wr_pos[5:2]][{~wr_pos[1:0], 3'b000} +: 8] <= wr_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_block) begin
         for (int i = 0; i < 8; i++) work_ff[i] <= chain_ff[i];
         round_ff <= '0;
      end else if (cmd.round_step) begin
         work_ff[7] <= work_ff[6];
         work_ff[6] <= work_ff[5];
         work_ff[5] <= work_ff[4];
         work_ff[4] <= work_ff[3] + t1;
         work_ff[3] <= work_ff[2];
         work_ff[2] <= work_ff[1];
         work_ff[1] <= work_ff[0];
         work_ff[0] <= t1 + t2;
         round_ff <= round_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.reset_chain) begin
         for (int i = 0; i < 8; i++) chain_ff[i] <= init_hash(3'(i));
      end else if (cmd.finish_block) begin
         for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + work_ff[i];
      end else if (cmd.shift_digest) begin
         // The digest leaves through word 0; words rotate down one place.
         for (int i = 0; i < 7; i++) chain_ff[i] <= chain_ff[i+1];
         chain_ff[7] <= chain_ff[0];
      end
   end

   assign digest_word = chain_ff[0];
   assign status.fill_pos = count_ff[5:0];
   assign status.round_num = round_ff;
   assign status.bit_len = {count_ff[60:0], 3'b000};

endmodule

// ----- src/sha_control.sv -----
// Controller state machine of the SHA-256 hasher.
module sha_control (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic byte_present,
   input  logic end_of_message,
   input  sha_pkg::status_type status,
   output sha_pkg::cmd_type cmd,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [2:0] word_index
);
   import sha_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_START  = 7'b0000010,
      ST_ROUND  = 7'b0000100,
      ST_FINISH = 7'b0001000,
      ST_PAD    = 7'b0010000,
      ST_OUT    = 7'b0100000,
      ST_RESET  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic closing_ff, closing_in;   // pending end of message
   logic final_ff, final_in;       // current block carries the length
   logic [6:0] pad_ff, pad_in;     // next pad byte position, 64 means done
   logic [2:0] word_ff, word_in;

   logic accept;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign word_index = word_ff;

   always_comb begin
      state_in = state_ff;
      closing_in = closing_ff;
      final_in = final_ff;
      pad_in = pad_ff;
      word_in = word_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_byte = byte_present;
               closing_in = end_of_message;
               pad_in = {1'b0, status.fill_pos} + {6'd0, byte_present};
               if (byte_present && status.fill_pos == 6'd63) begin
                  final_in = 1'b0;
                  state_in = ST_START;
               end else if (end_of_message) begin
                  state_in = ST_PAD;
                  cmd.load_pad = 1'b0;
               end
            end
         end
         ST_PAD: begin
            // First pad byte is 0x80, then zeros, then the length in bytes 56..63.
            cmd.load_pad = 1'b1;
            cmd.pad_pos = pad_ff[5:0];
            if (pad_ff[5:0] == status.fill_pos && !final_ff) cmd.pad_val = PadByte;
            else if (pad_ff[5:0] >= 6'd56 && final_ff)
               cmd.pad_val = status.bit_len[8*(63 - pad_ff[5:0]) +: 8];
            else cmd.pad_val = 8'h00;
            pad_in = pad_ff + 7'd1;
            // Reaching byte 55 means the 0x80 byte sits at 55 or below, so the
            // length fits behind it in this block.
            if (pad_ff == 7'd55) begin
               final_in = 1'b1;
            end
            if (pad_ff == 7'd63) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.start_block = 1'b1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round_step = 1'b1;
            if (status.round_num == 6'd63) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish_block = 1'b1;
            if (final_ff) begin
               word_in = '0;
               state_in = ST_OUT;
            end else if (closing_ff) begin
               pad_in = {1'b0, status.fill_pos};
               if (status.fill_pos != 6'd0 || !closing_ff) pad_in = 7'd0;
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               cmd.shift_digest = 1'b1;
               word_in = word_ff + 3'd1;
               if (word_ff == 3'd7) state_in = ST_RESET;
            end
         end
         ST_RESET: begin
            cmd.reset_chain = 1'b1;
            closing_in = 1'b0;
            final_in = 1'b0;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         closing_ff <= 1'b0;
         final_ff <= 1'b0;
         pad_ff <= '0;
         word_ff <= '0;
      end else begin
         state_ff <= state_in;
         closing_ff <= closing_in;
         final_ff <= final_in;
         pad_ff <= pad_in;
         word_ff <= word_in;
      end
   end

endmodule
